// ----- rtl/ssd_pkg.sv -----
// Shared constants, field layout, controller states and the command and
// status structs for the sparse squared distance block.
// No dependencies; used by ssd_ctrl, ssd_datapath and the top level.
`timescale 1ns / 1ps

package ssd_pkg;

   // Dense store depth and the widths that follow from it.
   localparam int FEATURE_COUNT = 1024;
   localparam int ADDR_W        = $clog2(FEATURE_COUNT);
   localparam int COUNT_W       = $clog2(FEATURE_COUNT + 1);

   // Transaction fields.
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;
   localparam int NORM_W  = 63;
   localparam int DIST_W  = 64;
   localparam int PROD_W  = 2 * VALUE_W;

   // Request tdata layout, lowest field first, padded to whole bytes.
   localparam int INDEX_LSB  = 0;
   localparam int VALUE_LSB  = INDEX_LSB + INDEX_W;
   localparam int NORM_LSB   = VALUE_LSB + VALUE_W;
   localparam int REQ_BITS   = NORM_LSB + NORM_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = DIST_W;

   // Element kinds carried on req_tuser.
   localparam logic FUNC_REFERENCE = 1'b0;
   localparam logic FUNC_CANDIDATE = 1'b1;

   localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W - 1){1'b1}}};
   localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W - 1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLR_LIST,
      ST_CLR_ALL,
      ST_REF_WR,
      ST_CAND_MUL,
      ST_CAND_ACC,
      ST_CAND_FIN
   } ssd_state_type;

   typedef struct packed {
      logic accept;
      logic clr_start;
      logic clr_list_step;
      logic clr_all_step;
      logic clr_finish;
      logic ref_write;
      logic mul;
      logic acc;
      logic load_out;
   } ssd_cmd_type;

   typedef struct packed {
      logic after_cand;
      logic wipe_all;
      logic item_last;
      logic clr_list_done;
      logic clr_all_last;
      logic out_busy;
   } ssd_sts_type;

endpackage

// ----- rtl/sparse_squared_distance_top.sv -----
// Top level of the sparse squared distance block: joins the controller and
// the datapath. Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
`timescale 1ns / 1ps

// Usage:
// The req channel carries vector elements. req_tuser selects the kind of
// element (reference or candidate), req_tlast marks the final element of a
// vector, and req_tdata holds the feature index, the Q16.16 value and the
// Q32.32 squared norm (read only on the last element). Reference elements
// are scattered into a dense store. Each candidate element multiplies its
// value with the stored reference value at its index and accumulates; on a
// candidate's last element one transaction leaves on the rsp channel with
// the Q32.32 distance and a saturation flag.
// Timing: one element is worked on at a time. A reference element passes
// through accept and store write, a candidate element through accept,
// multiply and accumulate, and a candidate's last element also through a
// result load; the store read, the single multiplier and the accumulator
// each take a registered step. The first reference element after a
// candidate also clears the entries written before, one index list read
// per cycle, or runs a full store sweep instead after reset or after the
// index list ran full.
// Reset empties the result register and arms a full store sweep, which runs
// when the first reference element arrives. A stalled rsp receiver holds
// the result register; new elements are still taken until another result
// is ready to be loaded.

module sparse_squared_distance_top (
   input  logic                           clock,
   input  logic                           reset,
   // Element channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [9:0] feature_index, [41:10] feature_value, [104:42] squared_norm,
   // [111:105] zero padding.
   input  logic [ssd_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] func: 0 reference element, 1 candidate element.
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [63:0] distance.
   output logic [ssd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] saturated.
   output logic                           rsp_tuser
);

   ssd_pkg::ssd_cmd_type cmd;
   ssd_pkg::ssd_sts_type sts;

   // The controller sequences each transaction and owns the input handshake.
   ssd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // The datapath holds the store, the arithmetic and the result register.
   ssd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- rtl/ssd_ctrl.sv -----
// Controller state machine for the sparse squared distance block.
// Depends on ssd_pkg; drives ssd_datapath through ssd_cmd_type.
`timescale 1ns / 1ps

module ssd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   input  ssd_pkg::ssd_sts_type sts,
   output ssd_pkg::ssd_cmd_type cmd
);

   ssd_pkg::ssd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == ssd_pkg::FUNC_CANDIDATE) begin
                  state_in = ssd_pkg::ST_CAND_MUL;
               end else if (sts.after_cand) begin
                  state_in = sts.wipe_all ? ssd_pkg::ST_CLR_ALL : ssd_pkg::ST_CLR_LIST;
               end else begin
                  state_in = ssd_pkg::ST_REF_WR;
               end
            end
         end
         ssd_pkg::ST_CLR_LIST: begin
            if (sts.clr_list_done) begin
               state_in = ssd_pkg::ST_REF_WR;
            end
         end
         ssd_pkg::ST_CLR_ALL: begin
            if (sts.clr_all_last) begin
               state_in = ssd_pkg::ST_REF_WR;
            end
         end
         ssd_pkg::ST_REF_WR: begin
            state_in = ssd_pkg::ST_IDLE;
         end
         ssd_pkg::ST_CAND_MUL: begin
            state_in = ssd_pkg::ST_CAND_ACC;
         end
         ssd_pkg::ST_CAND_ACC: begin
            state_in = sts.item_last ? ssd_pkg::ST_CAND_FIN : ssd_pkg::ST_IDLE;
         end
         ssd_pkg::ST_CAND_FIN: begin
            if (!sts.out_busy) begin
               state_in = ssd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssd_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ssd_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.accept    = req_tvalid;
            cmd.clr_start = req_tvalid && (req_tuser == ssd_pkg::FUNC_REFERENCE) &&
                            sts.after_cand;
         end
         ssd_pkg::ST_CLR_LIST: begin
            cmd.clr_list_step = 1'b1;
            cmd.clr_finish    = sts.clr_list_done;
         end
         ssd_pkg::ST_CLR_ALL: begin
            cmd.clr_all_step = 1'b1;
            cmd.clr_finish   = sts.clr_all_last;
         end
         ssd_pkg::ST_REF_WR: begin
            cmd.ref_write = 1'b1;
         end
         ssd_pkg::ST_CAND_MUL: begin
            cmd.mul = 1'b1;
         end
         ssd_pkg::ST_CAND_ACC: begin
            cmd.acc = 1'b1;
         end
         ssd_pkg::ST_CAND_FIN: begin
            cmd.load_out = !sts.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- rtl/ssd_datapath.sv -----
// Datapath of the sparse squared distance block: item registers, the dense
// reference store and index list memories, multiplier, saturating
// accumulator, final distance and the result register. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ssd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ssd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   input  ssd_pkg::ssd_cmd_type              cmd,
   output ssd_pkg::ssd_sts_type              sts
);

   // Request fields.
   logic [ssd_pkg::INDEX_W-1:0]        req_idx;
   logic signed [ssd_pkg::VALUE_W-1:0] req_value;
   logic [ssd_pkg::NORM_W-1:0]         req_norm;
   logic                               req_idx_ok;

   assign req_idx    = req_tdata[ssd_pkg::INDEX_LSB +: ssd_pkg::INDEX_W];
   assign req_value  = $signed(req_tdata[ssd_pkg::VALUE_LSB +: ssd_pkg::VALUE_W]);
   assign req_norm   = req_tdata[ssd_pkg::NORM_LSB +: ssd_pkg::NORM_W];
   assign req_idx_ok = int'(req_idx) < ssd_pkg::FEATURE_COUNT;

   // Captured item (payload, no reset).
   logic [ssd_pkg::INDEX_W-1:0]        idx_ff, idx_in;
   logic                               idx_ok_ff, idx_ok_in;
   logic signed [ssd_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [ssd_pkg::NORM_W-1:0]         norm_ff, norm_in;
   logic                               last_ff, last_in;

   // Control state.
   logic                               after_cand_ff, after_cand_in;
   logic                               wipe_all_ff, wipe_all_in;
   logic                               blank_ff, blank_in;
   logic [ssd_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [ssd_pkg::COUNT_W-1:0]        clr_cnt_ff, clr_cnt_in;
   logic                               pend_ff, pend_in;
   logic [ssd_pkg::NORM_W-1:0]         ref_norm_ff, ref_norm_in;
   logic signed [ssd_pkg::DIST_W-1:0]  sum_ff, sum_in;
   logic                               sum_clamped_ff, sum_clamped_in;
   logic signed [ssd_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [ssd_pkg::DIST_W-1:0]         rsp_dist_ff, rsp_dist_in;
   logic                               rsp_sat_ff, rsp_sat_in;

   // Memories.
   logic signed [ssd_pkg::VALUE_W-1:0] store_mem [ssd_pkg::FEATURE_COUNT];
   logic [ssd_pkg::INDEX_W-1:0]        list_mem  [ssd_pkg::FEATURE_COUNT];
   logic signed [ssd_pkg::VALUE_W-1:0] store_rd_ff;
   logic [ssd_pkg::INDEX_W-1:0]        list_rd_ff;

   logic                               store_we;
   logic [ssd_pkg::ADDR_W-1:0]         store_waddr;
   logic signed [ssd_pkg::VALUE_W-1:0] store_wdata;
   logic                               list_we;
   logic                               list_has_room;

   assign list_has_room = count_ff < ssd_pkg::COUNT_W'(ssd_pkg::FEATURE_COUNT);
   assign list_we       = cmd.ref_write && idx_ok_ff && list_has_room;

   // Single store write port: reference write, list-driven zeroing or sweep.
   always_comb begin
      store_we    = 1'b0;
      store_waddr = clr_cnt_ff[ssd_pkg::ADDR_W-1:0];
      store_wdata = '0;
      if (cmd.ref_write && idx_ok_ff) begin
         store_we    = 1'b1;
         store_waddr = ssd_pkg::ADDR_W'(idx_ff);
         store_wdata = value_ff;
      end else if (pend_ff) begin
         store_we    = 1'b1;
         store_waddr = ssd_pkg::ADDR_W'(list_rd_ff);
      end else if (cmd.clr_all_step) begin
         store_we    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (cmd.accept) begin
         store_rd_ff <= store_mem[ssd_pkg::ADDR_W'(req_idx)];
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[count_ff[ssd_pkg::ADDR_W-1:0]] <= idx_ff;
      end
      list_rd_ff <= list_mem[clr_cnt_ff[ssd_pkg::ADDR_W-1:0]];
   end

   // Multiply, accumulate and final distance arithmetic.
   logic signed [ssd_pkg::VALUE_W-1:0]  mul_b;
   logic signed [ssd_pkg::DIST_W:0]     acc_wide;
   logic                                acc_ovf;
   logic [ssd_pkg::DIST_W-1:0]          acc_sat;
   logic [ssd_pkg::DIST_W-1:0]          norm_total;
   logic signed [ssd_pkg::DIST_W+1:0]   dist_wide;
   logic                                dist_ovf;
   logic [ssd_pkg::DIST_W-1:0]          dist_sat;

   assign mul_b    = (blank_ff || !idx_ok_ff) ? '0 : store_rd_ff;
   assign acc_wide = $signed({sum_ff[ssd_pkg::DIST_W-1], sum_ff}) +
                     $signed({prod_ff[ssd_pkg::PROD_W-1], prod_ff});
   assign acc_ovf  = acc_wide[ssd_pkg::DIST_W] ^ acc_wide[ssd_pkg::DIST_W-1];
   assign acc_sat  = acc_ovf ? (acc_wide[ssd_pkg::DIST_W] ? ssd_pkg::DIST_MIN
                                                          : ssd_pkg::DIST_MAX)
                             : acc_wide[ssd_pkg::DIST_W-1:0];

   // Both norms are below 2^63, so their sum fits 64 unsigned bits; the
   // difference with twice the sum is exact in 66 signed bits.
   assign norm_total = {1'b0, norm_ff} + {1'b0, ref_norm_ff};
   assign dist_wide  = $signed({2'b00, norm_total}) -
                       $signed({sum_ff[ssd_pkg::DIST_W-1], sum_ff, 1'b0});
   assign dist_ovf   = (dist_wide[ssd_pkg::DIST_W+1:ssd_pkg::DIST_W-1] != 3'b000) &&
                       (dist_wide[ssd_pkg::DIST_W+1:ssd_pkg::DIST_W-1] != 3'b111);
   assign dist_sat   = dist_ovf ? (dist_wide[ssd_pkg::DIST_W+1] ? ssd_pkg::DIST_MIN
                                                                : ssd_pkg::DIST_MAX)
                                : dist_wide[ssd_pkg::DIST_W-1:0];

   always_comb begin
      idx_in         = idx_ff;
      idx_ok_in      = idx_ok_ff;
      value_in       = value_ff;
      norm_in        = norm_ff;
      last_in        = last_ff;
      after_cand_in  = after_cand_ff;
      wipe_all_in    = wipe_all_ff;
      blank_in       = blank_ff;
      count_in       = count_ff;
      clr_cnt_in     = clr_cnt_ff;
      pend_in        = 1'b0;
      ref_norm_in    = ref_norm_ff;
      sum_in         = sum_ff;
      sum_clamped_in = sum_clamped_ff;
      prod_in        = prod_ff;
      rsp_dist_in    = rsp_dist_ff;
      rsp_sat_in     = rsp_sat_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (cmd.accept) begin
         idx_in    = req_idx;
         idx_ok_in = req_idx_ok;
         value_in  = req_value;
         norm_in   = req_norm;
         last_in   = req_tlast;
         if (req_tuser == ssd_pkg::FUNC_CANDIDATE) begin
            after_cand_in = 1'b1;
         end
      end

      if (cmd.clr_start) begin
         after_cand_in  = 1'b0;
         clr_cnt_in     = '0;
         sum_in         = '0;
         sum_clamped_in = 1'b0;
      end

      // List clear: read entry k this cycle, zero its store slot the next.
      if (cmd.clr_list_step && (clr_cnt_ff != count_ff)) begin
         pend_in    = 1'b1;
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      if (cmd.clr_all_step) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end

      if (cmd.clr_finish) begin
         count_in    = '0;
         wipe_all_in = 1'b0;
         blank_in    = 1'b0;
      end

      if (cmd.ref_write) begin
         if (idx_ok_ff) begin
            if (list_has_room) begin
               count_in = count_ff + 1'b1;
            end else begin
               wipe_all_in = 1'b1;
            end
         end
         if (last_ff) begin
            ref_norm_in = norm_ff;
         end
      end

      if (cmd.mul) begin
         prod_in = value_ff * mul_b;
      end

      if (cmd.acc) begin
         sum_in = acc_sat;
         if (acc_ovf) begin
            sum_clamped_in = 1'b1;
         end
      end

      if (cmd.load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_dist_in    = dist_sat;
         rsp_sat_in     = sum_clamped_ff || dist_ovf;
         sum_in         = '0;
         sum_clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      value_ff    <= value_in;
      norm_ff     <= norm_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_sat_ff  <= rsp_sat_in;
      clr_cnt_ff  <= clr_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_cand_ff  <= 1'b1;
         wipe_all_ff    <= 1'b1;
         blank_ff       <= 1'b1;
         count_ff       <= '0;
         pend_ff        <= 1'b0;
         ref_norm_ff    <= '0;
         sum_ff         <= '0;
         sum_clamped_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         after_cand_ff  <= after_cand_in;
         wipe_all_ff    <= wipe_all_in;
         blank_ff       <= blank_in;
         count_ff       <= count_in;
         pend_ff        <= pend_in;
         ref_norm_ff    <= ref_norm_in;
         sum_ff         <= sum_in;
         sum_clamped_ff <= sum_clamped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign sts.after_cand    = after_cand_ff;
   assign sts.wipe_all      = wipe_all_ff;
   assign sts.item_last     = last_ff;
   assign sts.clr_list_done = (clr_cnt_ff == count_ff) && !pend_ff;
   assign sts.clr_all_last  = clr_cnt_ff == ssd_pkg::COUNT_W'(ssd_pkg::FEATURE_COUNT - 1);
   assign sts.out_busy      = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_dist_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // The index list can never hold more entries than the store has slots.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ssd_pkg::COUNT_W'(ssd_pkg::FEATURE_COUNT))
      else $error("reference index count exceeds the store depth");

   // A pending list-driven zero write must drain before the reference write.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      cmd.ref_write |-> !pend_ff)
      else $error("store write port clash between clear and reference write");

   // A new result is loaded only when the previous one has been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register overwritten while stalled");

   // While the store holds power-up contents, the next clear must sweep it all.
   a_blank_wipes: assert property (@(posedge clock) disable iff (reset)
      blank_ff |-> wipe_all_ff)
      else $error("store not scheduled for a full sweep after reset");

endmodule

// ----- tb/sv/sparse_squared_distance_top_tb.sv -----
// Self-checking testbench for sparse_squared_distance_top: streams reference and
// candidate elements and compares every distance with an in-bench prediction.
// Depends on ssd_pkg and the sparse_squared_distance_top RTL.
`timescale 1ns / 1ps

module sparse_squared_distance_top_tb;

   // Cycles without any accepted transaction before the run is declared hung.
   // Worst honest case: a full store sweep overlapping a receiver hold-off
   // (RSP_HOLD_CYCLES) plus sender and receiver gaps.
   localparam int WATCHDOG_LIMIT  = 6000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int IDLE_PERCENT    = 18;
   localparam int DRAIN_CYCLES    = 40;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic [ssd_pkg::DIST_W-1:0] distance;
      logic                       saturated;
   } distance_result_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ssd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = ssd_pkg::FUNC_REFERENCE;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ssd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   // Shadow of the block state, updated at each accepted element.
   logic signed [ssd_pkg::VALUE_W-1:0] ref_values [ssd_pkg::FEATURE_COUNT];
   logic [ssd_pkg::INDEX_W-1:0]        ref_indices [ssd_pkg::FEATURE_COUNT];
   int unsigned                        ref_count   = 0;
   logic [ssd_pkg::NORM_W-1:0]         ref_norm    = '0;
   logic signed [ssd_pkg::DIST_W-1:0]  running_sum = '0;
   bit                                 after_cand  = 1'b1;
   bit                                 list_full   = 1'b0;
   bit                                 sum_sat     = 1'b0;

   distance_result_type pending_distances[$];

   // Run control and statistics.
   bit idle_enable       = 1'b1;
   int hold_asked        = 0;
   int hold_taken        = 0;
   int hold_left         = 0;
   int idle_streak       = 0;
   int failures          = 0;
   int elements_sent     = 0;
   int reference_sent    = 0;
   int candidate_sent    = 0;
   int distances_checked = 0;
   int saturated_seen    = 0;

   sparse_squared_distance_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every failure goes through here; only the first few are spelled out.
   function automatic void report_failure(input string what);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, what);
      end
   endfunction

   // Applies one accepted element to the shadow state. A candidate's last
   // element pushes the distance it must produce.
   function automatic void predict_distance(input logic func,
         input logic [ssd_pkg::INDEX_W-1:0] index,
         input logic signed [ssd_pkg::VALUE_W-1:0] value,
         input logic [ssd_pkg::NORM_W-1:0] norm, input logic last);
      logic signed [ssd_pkg::DIST_W-1:0] product;
      logic signed [ssd_pkg::DIST_W:0]   wide_sum;
      logic signed [ssd_pkg::DIST_W-1:0] sum_ext_src;
      logic signed [ssd_pkg::DIST_W+2:0] sum_ext;
      logic signed [ssd_pkg::DIST_W+2:0] exact;
      distance_result_type               outcome;
      if (func == ssd_pkg::FUNC_REFERENCE) begin
         // The first reference element after any candidate starts a new
         // reference: wipe what was scattered and drop any open candidate.
         if (after_cand) begin
            if (list_full) begin
               foreach (ref_values[k]) ref_values[k] = '0;
            end else begin
               for (int k = 0; k < ref_count; k++) ref_values[ref_indices[k]] = '0;
            end
            ref_count   = 0;
            list_full   = 1'b0;
            running_sum = '0;
            sum_sat     = 1'b0;
            after_cand  = 1'b0;
         end
         if (index < ssd_pkg::FEATURE_COUNT) begin
            ref_values[index] = value;
            if (ref_count < ssd_pkg::FEATURE_COUNT) begin
               ref_indices[ref_count] = index;
               ref_count++;
            end else begin
               list_full = 1'b1;
            end
         end
         if (last) begin
            ref_norm = norm;
         end
      end else begin
         after_cand = 1'b1;
         if (index < ssd_pkg::FEATURE_COUNT) begin
            product  = value * ref_values[index];
            wide_sum = running_sum + product;
            if (wide_sum[ssd_pkg::DIST_W] != wide_sum[ssd_pkg::DIST_W-1]) begin
               sum_sat     = 1'b1;
               running_sum = wide_sum[ssd_pkg::DIST_W] ? ssd_pkg::DIST_MIN
                                                       : ssd_pkg::DIST_MAX;
            end else begin
               running_sum = wide_sum[ssd_pkg::DIST_W-1:0];
            end
         end
         if (last) begin
            // Evaluate n + r - 2*s exactly in 67 bits, then clamp once.
            sum_ext_src = running_sum;
            sum_ext     = sum_ext_src;
            exact = $signed({4'b0, norm}) + $signed({4'b0, ref_norm}) - 2 * sum_ext;
            outcome.saturated = sum_sat;
            if (exact[ssd_pkg::DIST_W+2:ssd_pkg::DIST_W-1] !=
                {4{exact[ssd_pkg::DIST_W-1]}}) begin
               outcome.saturated = 1'b1;
               outcome.distance  = exact[ssd_pkg::DIST_W+2] ? ssd_pkg::DIST_MIN
                                                            : ssd_pkg::DIST_MAX;
            end else begin
               outcome.distance = exact[ssd_pkg::DIST_W-1:0];
            end
            pending_distances.push_back(outcome);
            running_sum = '0;
            sum_sat     = 1'b0;
         end
      end
   endfunction

   // Offers one element, occasionally after a short gap, and holds it until
   // the block takes it. Valid stays high afterwards so that back-to-back
   // calls stream without a bubble; the next call or a drain lowers it.
   task automatic send_element(input logic func, input logic [ssd_pkg::INDEX_W-1:0] index,
         input logic [ssd_pkg::VALUE_W-1:0] value, input logic [ssd_pkg::NORM_W-1:0] norm,
         input logic last);
      if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last;
      req_tdata  <= {{(ssd_pkg::REQ_DATA_W - ssd_pkg::REQ_BITS){1'b0}}, norm, value, index};
      do @(posedge clock); while (!req_tready);
      predict_distance(func, index, value, norm, last);
      elements_sent++;
      if (func == ssd_pkg::FUNC_REFERENCE) reference_sent++;
      else candidate_sent++;
   endtask

   // The sender stops and waits until every predicted distance has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
   endtask

   function automatic logic [ssd_pkg::INDEX_W-1:0] random_index();
      case ($urandom_range(3))
         0:       return ssd_pkg::INDEX_W'($urandom_range(0, 7));
         1:       return ssd_pkg::INDEX_W'(ssd_pkg::FEATURE_COUNT - 1 - $urandom_range(0, 3));
         default: return ssd_pkg::INDEX_W'($urandom_range(0, ssd_pkg::FEATURE_COUNT - 1));
      endcase
   endfunction

   function automatic logic [ssd_pkg::VALUE_W-1:0] random_value();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3, 4, 5: return {{12{r[20]}}, r[19:0]};
         default: return r;
      endcase
   endfunction

   function automatic logic [ssd_pkg::NORM_W-1:0] random_norm();
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(9))
         0:       return '0;
         1:       return {ssd_pkg::NORM_W{1'b1}};
         2, 3, 4: return {31'b0, r[31:0]};
         default: return r[ssd_pkg::NORM_W-1:0];
      endcase
   endfunction

   // Field extremes, every special case of the element stream, hand-built.
   task automatic test_directed_cases();
      // Reference with both value extremes, both index extremes and a
      // repeated index whose later value wins; maximum norm.
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd0,    32'h7FFF_FFFF, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd1023, 32'h8000_0000, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd5,    32'h0001_0000, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd5,    32'h0002_0000,
                   {ssd_pkg::NORM_W{1'b1}}, 1'b1);
      // Two products of 2^62 overflow the running sum.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd1023, 32'h8000_0000, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd1023, 32'h8000_0000, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd0,    32'h0000_0000, 63'd0, 1'b1);
      // Plain in-range distance using the overwritten entry.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd5,    32'h0003_0000, 63'd0, 1'b1);
      // Unwritten index contributes zero; both norms at maximum clamp high.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd700,  32'h1234_5678,
                   {ssd_pkg::NORM_W{1'b1}}, 1'b1);
      // Negative sum with a maximum norm also clamps high.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd1023, 32'h7FFF_FFFF, 63'd0, 1'b1);
      // New reference; the second element has no last flag, so its norm is
      // ignored and the reference norm stays zero.
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd3, 32'h7FFF_FFFF, 63'd0, 1'b1);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd4, 32'h7FFF_FFFF,
                   {ssd_pkg::NORM_W{1'b1}}, 1'b0);
      // Large positive sum drives the distance below the negative limit.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd3, 32'h7FFF_FFFF, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd4, 32'h7FFF_FFFF, 63'd0, 1'b1);
      // Index 1023 was cleared by the new reference.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd1023, 32'h1234_5678, 63'd0, 1'b1);
      // An unfinished candidate, dropped by the next reference.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd3, 32'h0001_0000, 63'd5, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd3, 32'h0001_0000, 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd9, 32'h8000_0000, 63'd0, 1'b1);
      // Small negative distance, then exactly the most negative value
      // without clamping.
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd3, 32'h0001_0000, 63'd0, 1'b1);
      send_element(ssd_pkg::FUNC_CANDIDATE, 10'd9, 32'h8000_0000, 63'd0, 1'b1);
   endtask

   // A reference longer than the index list forces a full store wipe on the
   // next reference; the following candidates probe for stale entries.
   task automatic test_index_list_overflow();
      for (int k = 0; k < ssd_pkg::FEATURE_COUNT + 6; k++) begin
         send_element(ssd_pkg::FUNC_REFERENCE,
                      ssd_pkg::INDEX_W'(k % ssd_pkg::FEATURE_COUNT), $urandom,
                      random_norm(), k == ssd_pkg::FEATURE_COUNT + 5);
      end
      repeat (8) send_element(ssd_pkg::FUNC_CANDIDATE, random_index(), random_value(),
                              random_norm(), 1'($urandom_range(1)));
      send_element(ssd_pkg::FUNC_CANDIDATE, random_index(), random_value(), random_norm(),
                   1'b1);
      send_element(ssd_pkg::FUNC_REFERENCE, 10'd2, random_value(), random_norm(), 1'b1);
      repeat (8) send_element(ssd_pkg::FUNC_CANDIDATE, random_index(), random_value(),
                              63'd0, 1'b1);
   endtask

   // The receiver holds off for a long stretch while candidates keep coming,
   // so the result register fills and the block stops taking elements.
   task automatic test_backpressure();
      send_element(ssd_pkg::FUNC_REFERENCE, random_index(), random_value(), 63'd0, 1'b0);
      send_element(ssd_pkg::FUNC_REFERENCE, random_index(), random_value(), random_norm(),
                   1'b1);
      hold_asked++;
      repeat (16) send_element(ssd_pkg::FUNC_CANDIDATE, random_index(), random_value(),
                               random_norm(), 1'b1);
   endtask

   // Mostly well-formed reference/candidate groups with random content; some
   // groups are broken: a reference without its last flag, or a final
   // candidate left open so the next reference drops it.
   task automatic test_random_traffic(input int item_goal);
      int                          start_count;
      int                          ref_len;
      int                          cand_total;
      int                          cand_len;
      bit                          broken;
      logic [ssd_pkg::INDEX_W-1:0] used_indices[$];
      logic [ssd_pkg::INDEX_W-1:0] index;
      start_count = elements_sent;
      while (elements_sent - start_count < item_goal) begin
         // A stretch in the middle of the run has no idling on either side.
         idle_enable = !((elements_sent - start_count) > item_goal / 3 &&
                         (elements_sent - start_count) < item_goal / 2);
         broken  = ($urandom_range(99) < 15);
         ref_len = $urandom_range(1, 6);
         used_indices.delete();
         for (int k = 0; k < ref_len; k++) begin
            index = random_index();
            used_indices.push_back(index);
            send_element(ssd_pkg::FUNC_REFERENCE, index, random_value(), random_norm(),
                         (k == ref_len - 1) && !(broken && $urandom_range(1)));
         end
         cand_total = $urandom_range(1, 5);
         for (int c = 0; c < cand_total; c++) begin
            cand_len = $urandom_range(1, 6);
            for (int k = 0; k < cand_len; k++) begin
               if ($urandom_range(9) < 7) begin
                  index = used_indices[$urandom_range(0, used_indices.size() - 1)];
               end else begin
                  index = random_index();
               end
               send_element(ssd_pkg::FUNC_CANDIDATE, index, random_value(), random_norm(),
                            (k == cand_len - 1) && !(broken && c == cand_total - 1));
            end
         end
      end
      idle_enable = 1'b1;
   endtask

   // Receiver: random stalls, plus a long hold-off counted here on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         rsp_tready <= 1'b0;
         hold_left  <= RSP_HOLD_CYCLES;
         hold_taken <= hold_asked;
      end else if (idle_enable && $urandom_range(99) < IDLE_PERCENT) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker: each accepted transaction against the oldest prediction.
   always @(posedge clock) begin
      distance_result_type wanted;
      if (!reset && rsp_tvalid && rsp_tready) begin
         distances_checked++;
         if (rsp_tuser) saturated_seen++;
         if (pending_distances.size() == 0) begin
            report_failure($sformatf("unexpected result: distance %h saturated %b",
                                     rsp_tdata, rsp_tuser));
         end else begin
            wanted = pending_distances.pop_front();
            if (rsp_tdata !== wanted.distance || rsp_tuser !== wanted.saturated) begin
               report_failure($sformatf(
                  "distance mismatch: expected %h saturated %b, got %h saturated %b",
                  wanted.distance, wanted.saturated, rsp_tdata, rsp_tuser));
            end
         end
      end
   end

   // Watchdog: ends the run after too long without any accepted transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_streak = 0;
      end else begin
         idle_streak++;
         if (idle_streak >= WATCHDOG_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
                     idle_streak, pending_distances.size());
            $display("sparse_squared_distance_top regression: fail");
            $finish;
         end
      end
   end

   initial begin
      foreach (ref_values[k]) ref_values[k] = '0;
      foreach (ref_indices[k]) ref_indices[k] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      wait_for_drain();
      test_index_list_overflow();
      wait_for_drain();
      test_backpressure();
      wait_for_drain();
      test_random_traffic(500);
      wait_for_drain();

      // Let any late, unpredicted result show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_distances.size() != 0) begin
         report_failure($sformatf("%0d predicted results never arrived",
                                  pending_distances.size()));
      end

      $display("Sent %0d elements (%0d reference, %0d candidate), including an overflowing",
               elements_sent, reference_sent, candidate_sent);
      $display("reference and a long receiver hold-off; checked %0d distances, %0d saturated.",
               distances_checked, saturated_seen);
      if (failures == 0) begin
         $display("sparse_squared_distance_top regression: pass");
      end else begin
         $display("%0d failures in total", failures);
         $display("sparse_squared_distance_top regression: fail");
      end
      $finish;
   end

endmodule

// ----- sparse_squared_distance_top.f -----
rtl/ssd_pkg.sv
rtl/ssd_ctrl.sv
rtl/ssd_datapath.sv
rtl/sparse_squared_distance_top.sv
tb/sv/sparse_squared_distance_top_tb.sv
